@@ rtl/frm_pkg.sv @@
// Shared types and codes for the flash record ring manager.
// Depends on nothing; imported by frm_ctrl, frm_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none

package frm_pkg;

  typedef enum logic [1:0] {
    FUNC_SCAN    = 2'd0,
    FUNC_SAVE    = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_CONSUME = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_PROG_REC  = 3'd1,
    CMD_READ_REC  = 3'd2,
    CMD_PROG_MARK = 3'd3,
    CMD_ERASE     = 3'd4,
    CMD_SCAN_NEXT = 3'd5
  } cmd_e;

  localparam logic [7:0] MARK_FREE = 8'hFF;
  localparam logic [7:0] MARK_SENT = 8'h00;
  localparam logic [7:0] SLOT_BYTES_RST = 8'd8;

  typedef struct packed {
    logic load;
    logic exec;
    logic pop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic two_words;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/flash_record_ring_manager.sv @@
// Top level of the flash record ring manager: controller plus datapath.
// Depends on frm_pkg, frm_ctrl and frm_dp.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid_i/in_ready_o  | func_i marker_byte_i timestamp_i person_id_i
//  out     | out_valid_o/out_ready_i| ok_o command_o flash_address_o write_data_o
//          |                        | scan_done_o last_o
//  cfg     | cfg_we_i               | cfg_wdata_i (slot bytes)
//
// A word is taken into a hold register, executed once the output stage is
// empty, and its results are registered in the output stage. A consume that
// crosses into the next block adds an erase of the block it leaves as a second result.
// The next input word is taken while results wait in the output stage.
// Reset clears the pointers, their valid bits and the scan position.
`timescale 1ns / 1ps
`default_nettype none

module flash_record_ring_manager #(
  parameter int BLOCK_BYTES = 32768,
  parameter int NUM_BLOCKS  = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [7:0]  marker_byte_i,
  input  wire logic [31:0] timestamp_i,
  input  wire logic [31:0] person_id_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             ok_o,
  output logic [2:0]       command_o,
  output logic [16:0]      flash_address_o,
  output logic [63:0]      write_data_o,
  output logic             scan_done_o,
  output logic             last_o
);
  import frm_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  frm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (ctrl_cmd)
  );

  frm_dp #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .NUM_BLOCKS  (NUM_BLOCKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .stat_o          (dp_stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (func_i),
    .marker_byte_i   (marker_byte_i),
    .timestamp_i     (timestamp_i),
    .person_id_i     (person_id_i),
    .ok_o            (ok_o),
    .command_o       (command_o),
    .flash_address_o (flash_address_o),
    .write_data_o    (write_data_o),
    .scan_done_o     (scan_done_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

@@ rtl/frm_ctrl.sv @@
// Controller: input hold state machine and output word count.
// Depends on frm_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module frm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire frm_pkg::dp_stat_t stat_i,
  output frm_pkg::ctrl_cmd_t     cmd_o
);
  import frm_pkg::*;

  typedef enum logic {
    ST_EMPTY,
    ST_HELD
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] out_cnt_q, out_cnt_d;
  logic       in_acc, out_acc, exec;

  assign in_ready_o  = (state_q == ST_EMPTY);
  assign out_valid_o = (out_cnt_q != 2'd0);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_acc     = out_valid_o & out_ready_i;
  assign exec        = (state_q == ST_HELD) && (out_cnt_q == 2'd0);

  assign cmd_o.load = in_acc;
  assign cmd_o.exec = exec;
  assign cmd_o.pop  = out_acc && (out_cnt_q == 2'd2);

  always_comb begin
    state_d   = state_q;
    out_cnt_d = out_cnt_q;
    unique case (state_q)
      ST_EMPTY: begin
        if (in_acc) begin
          state_d = ST_HELD;
        end
      end
      ST_HELD: begin
        if (exec) begin
          state_d = ST_EMPTY;
        end
      end
      default: state_d = ST_EMPTY;
    endcase
    if (exec) begin
      out_cnt_d = stat_i.two_words ? 2'd2 : 2'd1;
    end else if (out_acc) begin
      out_cnt_d = out_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_EMPTY;
      out_cnt_q <= 2'd0;
    end else begin
      state_q   <= state_d;
      out_cnt_q <= out_cnt_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q != 2'd3)
    else $error("output word count out of range");

  a_exec_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> (out_cnt_q != 2'd0) && (state_q == ST_EMPTY))
    else $error("execute did not produce output words");

  a_accept_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o && (out_cnt_q == $past(out_cnt_q) ||
                               out_cnt_q == $past(out_cnt_q) - 2'd1))
    else $error("accept did not hold the word");

  a_pop_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |=> out_cnt_q == 2'd1)
    else $error("second word not left after pop");

endmodule

`default_nettype wire

@@ rtl/frm_dp.sv @@
// Datapath: pointer registers, scan state, held input word, output words.
// Depends on frm_pkg for codes and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module frm_dp #(
  parameter int BLOCK_BYTES = 32768,
  parameter int NUM_BLOCKS  = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire frm_pkg::ctrl_cmd_t cmd_i,
  output frm_pkg::dp_stat_t       stat_o,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i,
  input  wire logic [1:0]         func_i,
  input  wire logic [7:0]         marker_byte_i,
  input  wire logic [31:0]        timestamp_i,
  input  wire logic [31:0]        person_id_i,
  output logic                    ok_o,
  output logic [2:0]              command_o,
  output logic [16:0]             flash_address_o,
  output logic [63:0]             write_data_o,
  output logic                    scan_done_o,
  output logic                    last_o
);
  import frm_pkg::*;

  localparam int OFF_W = $clog2(BLOCK_BYTES);
  localparam int SUM_W = OFF_W + 2;
  localparam int BLK_W = $clog2(NUM_BLOCKS);
  localparam logic [SUM_W-1:0] BB_S   = SUM_W'(BLOCK_BYTES);
  localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(NUM_BLOCKS - 1);

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_FREE,
    KIND_SENT,
    KIND_PEND
  } kind_e;

  logic [7:0]       slot_q;
  logic [BLK_W-1:0] wp_blk_q, wp_blk_d, sp_blk_q, sp_blk_d, sc_blk_q, sc_blk_d;
  logic [OFF_W-1:0] wp_off_q, wp_off_d, sp_off_q, sp_off_d, sc_off_q, sc_off_d;
  logic             wv_q, wv_d, sv_q, sv_d, rp_q, rp_d;
  kind_e            kind_q, kind_d;

  func_e            func_q;
  logic [7:0]       marker_q;
  logic [31:0]      ts_q, pid_q;

  logic             ok_q, ok_d, done_q, done_d, last_q;
  cmd_e             cmd_q, cmd_d;
  logic [16:0]      addr_q, erase_addr_q;
  logic [63:0]      data_q, data_d;

  logic [7:0]       slot;
  logic [SUM_W-1:0] step_sum;
  logic             step_cross;
  logic [BLK_W-1:0] sel_blk;
  logic [OFF_W-1:0] sel_off;
  logic             sel_zero;
  logic [31:0]      addr_full, erase_full;
  logic             two_d;
  logic             scan_start, wv_s, sv_s;
  kind_e            kind_s;

  assign slot = (slot_q == 8'd0) ? 8'd1 : slot_q;

  always_comb begin
    wp_blk_d   = wp_blk_q;
    wp_off_d   = wp_off_q;
    sp_blk_d   = sp_blk_q;
    sp_off_d   = sp_off_q;
    sc_blk_d   = sc_blk_q;
    sc_off_d   = sc_off_q;
    wv_d       = wv_q;
    sv_d       = sv_q;
    rp_d       = rp_q;
    kind_d     = kind_q;
    ok_d       = 1'b0;
    cmd_d      = CMD_NONE;
    data_d     = 64'd0;
    done_d     = 1'b0;
    two_d      = 1'b0;
    sel_blk    = '0;
    sel_off    = '0;
    sel_zero   = 1'b1;
    step_sum   = '0;
    step_cross = 1'b0;
    scan_start = (sc_blk_q == '0) && (sc_off_q == '0);
    wv_s       = scan_start ? 1'b0 : wv_q;
    sv_s       = scan_start ? 1'b0 : sv_q;
    kind_s     = scan_start ? KIND_NONE : kind_q;
    unique case (func_q)
      FUNC_SCAN: begin
        wv_d     = wv_s;
        sv_d     = sv_s;
        ok_d     = 1'b1;
        cmd_d    = CMD_SCAN_NEXT;
        step_sum = SUM_W'(sc_off_q) + SUM_W'(slot);
        if (marker_q == MARK_FREE) begin
          if (!wv_s || kind_s == KIND_SENT || kind_s == KIND_PEND) begin
            wp_blk_d = sc_blk_q;
            wp_off_d = sc_off_q;
            wv_d     = 1'b1;
          end
          kind_d     = KIND_FREE;
          step_cross = 1'b1;
        end else begin
          if (marker_q == MARK_SENT) begin
            kind_d = KIND_SENT;
          end else begin
            if (!sv_s || kind_s == KIND_FREE || kind_s == KIND_SENT) begin
              sp_blk_d = sc_blk_q;
              sp_off_d = sc_off_q;
              sv_d     = 1'b1;
            end
            kind_d = KIND_PEND;
          end
          step_cross = (step_sum + SUM_W'(slot)) > BB_S;
        end
        if (step_cross) begin
          sc_off_d = '0;
          if (sc_blk_q == BLK_LAST) begin
            sc_blk_d = '0;
            done_d   = 1'b1;
          end else begin
            sc_blk_d = sc_blk_q + BLK_W'(1);
          end
        end else begin
          sc_off_d = OFF_W'(step_sum);
        end
        sel_blk  = sc_blk_d;
        sel_off  = sc_off_d;
        sel_zero = done_d;
      end
      FUNC_SAVE: begin
        if (wv_q) begin
          ok_d     = 1'b1;
          cmd_d    = CMD_PROG_REC;
          data_d   = {ts_q, pid_q};
          sel_blk  = wp_blk_q;
          sel_off  = wp_off_q;
          sel_zero = 1'b0;
          if (!sv_q) begin
            sp_blk_d = wp_blk_q;
            sp_off_d = wp_off_q;
            sv_d     = 1'b1;
          end
          step_sum = SUM_W'(wp_off_q) + SUM_W'(slot);
          if ((step_sum + SUM_W'(slot)) > BB_S) begin
            wp_off_d = '0;
            if (wp_blk_q == BLK_LAST) begin
              wp_blk_d = '0;
            end else begin
              wp_blk_d = wp_blk_q + BLK_W'(1);
            end
            if (sp_blk_d == wp_blk_d) begin
              wv_d = 1'b0;
            end
          end else begin
            wp_off_d = OFF_W'(step_sum);
          end
        end
      end
      FUNC_READ: begin
        if (sv_q) begin
          rp_d     = 1'b1;
          ok_d     = 1'b1;
          cmd_d    = CMD_READ_REC;
          sel_blk  = sp_blk_q;
          sel_off  = sp_off_q;
          sel_zero = 1'b0;
        end
      end
      FUNC_CONSUME: begin
        rp_d = 1'b0;
        if (rp_q && sv_q) begin
          ok_d     = 1'b1;
          cmd_d    = CMD_PROG_MARK;
          sel_blk  = sp_blk_q;
          sel_off  = sp_off_q;
          sel_zero = 1'b0;
          step_sum = SUM_W'(sp_off_q) + SUM_W'(slot);
          if ((step_sum + SUM_W'(slot)) > BB_S) begin
            two_d    = 1'b1;
            sp_off_d = '0;
            if (sp_blk_q == BLK_LAST) begin
              sp_blk_d = '0;
            end else begin
              sp_blk_d = sp_blk_q + BLK_W'(1);
            end
          end else begin
            sp_off_d = OFF_W'(step_sum);
          end
          if (wv_q && sp_blk_d == wp_blk_q && sp_off_d == wp_off_q) begin
            sv_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign addr_full  = 32'(sel_blk) * 32'(BLOCK_BYTES) + 32'(sel_off);
  assign erase_full = 32'(sp_blk_q) * 32'(BLOCK_BYTES);
  assign stat_o.two_words = two_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= SLOT_BYTES_RST;
      wp_blk_q <= '0;
      wp_off_q <= '0;
      sp_blk_q <= '0;
      sp_off_q <= '0;
      sc_blk_q <= '0;
      sc_off_q <= '0;
      wv_q     <= 1'b0;
      sv_q     <= 1'b0;
      rp_q     <= 1'b0;
      kind_q   <= KIND_NONE;
    end else begin
      if (cfg_we_i) begin
        slot_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        wp_blk_q <= wp_blk_d;
        wp_off_q <= wp_off_d;
        sp_blk_q <= sp_blk_d;
        sp_off_q <= sp_off_d;
        sc_blk_q <= sc_blk_d;
        sc_off_q <= sc_off_d;
        wv_q     <= wv_d;
        sv_q     <= sv_d;
        rp_q     <= rp_d;
        kind_q   <= kind_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= func_e'(func_i);
      marker_q <= marker_byte_i;
      ts_q     <= timestamp_i;
      pid_q    <= person_id_i;
    end
    if (cmd_i.exec) begin
      ok_q         <= ok_d;
      cmd_q        <= cmd_d;
      addr_q       <= sel_zero ? 17'd0 : addr_full[16:0];
      data_q       <= data_d;
      done_q       <= done_d;
      last_q       <= !two_d;
      erase_addr_q <= erase_full[16:0];
    end else if (cmd_i.pop) begin
      ok_q   <= 1'b1;
      cmd_q  <= CMD_ERASE;
      addr_q <= erase_addr_q;
      data_q <= 64'd0;
      done_q <= 1'b0;
      last_q <= 1'b1;
    end
  end

  assign ok_o            = ok_q;
  assign command_o       = cmd_q;
  assign flash_address_o = addr_q;
  assign write_data_o    = data_q;
  assign scan_done_o     = done_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire
